// File: src/sdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdo_pkg;

   // default configuration of the block
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // register file layout
   localparam int INC_W     = 32;
   localparam int WAVE_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETUNE   = 2'd2;

   localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;

   // pi/2 and 1.0 in q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

   // quarter-wave sine entry k, taylor series in q2.30 with truncating products,
   // scaled to full scale minus one and rounded; folded to a constant
   function automatic logic [63:0] sine_entry(input int k, input int table_bits,
                                              input int sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] r;
      logic [63:0] fm1;
      x   = (HALF_PI_Q30 * 64'(k)) >> (table_bits - 2);
      x2  = (x * x) >> 30;
      t   = Q30_ONE - x2 / 64'd110;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s   = (x * t) >> 30;
      fm1 = (64'd1 << (sample_bits - 1)) - 64'd1;
      r   = (s * fm1 + (Q30_ONE >> 1)) >> 30;
      if (r > fm1) begin
         r = fm1;
      end
      return r;
   endfunction

   // sign-extended 32-bit cycle fraction scaled to the phase width;
   // caller keeps the low phase bits
   function automatic logic [63:0] to_phase(input logic [63:0] v, input int pb);
      logic [63:0] res;
      if (pb >= 32) begin
         res = v << (pb - 32);
      end else begin
         res = v >> (32 - pb);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: src/sdo_phase.sv
`timescale 1ns / 1ps
`default_nettype none
module sdo_phase
   import sdo_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [INC_W-1:0]      freq_inc,
   input  wire logic [INC_W-1:0]      detune_inc,
   output logic      [PHASE_BITS-1:0] left_phase,
   output logic      [PHASE_BITS-1:0] right_phase
);

   logic [63:0]           freq_ext;
   logic [63:0]           detune_ext;
   logic [63:0]           left_step_wide;
   logic [63:0]           right_step_wide;
   logic [PHASE_BITS-1:0] left_phase_ff;
   logic [PHASE_BITS-1:0] left_phase_in;
   logic [PHASE_BITS-1:0] right_phase_ff;
   logic [PHASE_BITS-1:0] right_phase_in;

   assign freq_ext   = {{(64-INC_W){freq_inc[INC_W-1]}}, freq_inc};
   assign detune_ext = {{(64-INC_W){detune_inc[INC_W-1]}}, detune_inc};

   // left runs flat by the detune, right runs sharp
   assign left_step_wide  = to_phase(freq_ext - detune_ext, PHASE_BITS);
   assign right_step_wide = to_phase(freq_ext + detune_ext, PHASE_BITS);

   assign left_phase_in  = left_phase_ff + left_step_wide[PHASE_BITS-1:0];
   assign right_phase_in = right_phase_ff + right_step_wide[PHASE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_phase_ff  <= '0;
         right_phase_ff <= '0;
      end else if (advance) begin
         left_phase_ff  <= left_phase_in;
         right_phase_ff <= right_phase_in;
      end
   end

   assign left_phase  = left_phase_ff;
   assign right_phase = right_phase_ff;

endmodule
`default_nettype wire

// File: src/sdo_wave.sv
`timescale 1ns / 1ps
`default_nettype none
module sdo_wave
   import sdo_pkg::*;
#(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  wire logic [WAVE_W-1:0]      waveform,
   input  wire logic [PHASE_BITS-1:0]  phase,
   input  wire logic [PHASE_BITS-1:0]  phase_mod,
   output logic      [SAMPLE_BITS-1:0] sample
);

   localparam int QTR_BITS = SINE_TABLE_BITS - 2;
   localparam int QTR      = 1 << QTR_BITS;
   localparam int ROM_AW   = QTR_BITS + 1;

   // quarter-wave table, entries 0 through QTR inclusive
   logic [SAMPLE_BITS-1:0] sine_rom [QTR+1];

   for (genvar k = 0; k <= QTR; k++) begin : g_rom
      localparam logic [63:0] ENTRY = sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS);
      assign sine_rom[k] = ENTRY[SAMPLE_BITS-1:0];
   end

   logic [PHASE_BITS-1:0]  sine_phase;
   logic [1:0]             quad;
   logic [QTR_BITS-1:0]    idx;
   logic [ROM_AW-1:0]      rom_addr;
   logic [SAMPLE_BITS-1:0] rom_val;
   logic [SAMPLE_BITS-1:0] sine_val;
   logic [SAMPLE_BITS-1:0] square_val;
   logic [SAMPLE_BITS-1:0] saw_top;
   logic [SAMPLE_BITS-1:0] saw_val;
   logic [SAMPLE_BITS-1:0] full_pos;
   logic [SAMPLE_BITS-1:0] full_neg;

   assign full_pos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   assign full_neg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // sine: mirror in odd quadrants, negate in the second half cycle
   assign sine_phase = phase + phase_mod;
   assign quad       = sine_phase[PHASE_BITS-1 -: 2];
   assign idx        = sine_phase[PHASE_BITS-3 -: QTR_BITS];
   assign rom_addr   = quad[0] ? ROM_AW'(QTR) - {1'b0, idx} : {1'b0, idx};
   assign rom_val    = sine_rom[rom_addr];
   assign sine_val   = quad[1] ? -rom_val : rom_val;

   assign square_val = phase[PHASE_BITS-1] ? full_pos : full_neg;

   // saw: full scale minus the top phase bits, clipped at phase zero
   if (PHASE_BITS >= SAMPLE_BITS) begin : g_saw_trunc
      assign saw_top = phase[PHASE_BITS-1 -: SAMPLE_BITS];
   end else begin : g_saw_pad
      assign saw_top = {phase, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
   end

   assign saw_val = (saw_top == '0) ? full_pos : full_neg - saw_top;

   always_comb begin
      case (waveform)
         WAVE_SINE:   sample = sine_val;
         WAVE_SQUARE: sample = square_val;
         WAVE_SAW:    sample = saw_val;
         default:     sample = '0;
      endcase
   end

endmodule
`default_nettype wire

// File: src/stereo_detuned_oscillator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  ports               contents
// req       in         req_tvalid/tready   one sample tick: phase_mod
// rsp       out        rsp_tvalid/tready   left_sample, right_sample
// csr       in         csr_we/index/wdata  waveform, freq_increment, detune_increment
//
// one tick per cycle sustained while rsp is not stalled; a tick's samples pass from
// its transfer through the input register, then waveform logic into the result
// register, before they are valid on rsp
// the phase accumulators step on every req transfer, sampled before the step
// synchronous active-high reset clears phases, config and valid flags
// a stalled rsp holds its data; the input register keeps filling while the
// result register drains, so both sides may stall independently
module stereo_detuned_oscillator_top
   import sdo_pkg::*;
#(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [31:0] phase_mod

   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // left_sample, right_sample, zero pad
   output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [INC_W-1:0]     csr_wdata
);

   localparam int RSP_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   // configuration registers
   logic [WAVE_W-1:0] waveform_ff;
   logic [INC_W-1:0]  freq_inc_ff;
   logic [INC_W-1:0]  detune_inc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff   <= WAVE_SINE;
         freq_inc_ff   <= '0;
         detune_inc_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVEFORM: waveform_ff   <= csr_wdata[WAVE_W-1:0];
            CSR_FREQ:     freq_inc_ff   <= csr_wdata;
            CSR_DETUNE:   detune_inc_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // handshake: input stage moves on when the result register is free or draining
   logic req_xfer;
   logic s1_valid_ff;
   logic s1_adv;
   logic rsp_valid_ff;

   assign s1_adv     = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign req_xfer   = req_tvalid & req_tready;

   // phase accumulators
   logic [PHASE_BITS-1:0] left_phase;
   logic [PHASE_BITS-1:0] right_phase;

   sdo_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_xfer),
      .freq_inc    (freq_inc_ff),
      .detune_inc  (detune_inc_ff),
      .left_phase  (left_phase),
      .right_phase (right_phase)
   );

   // input register: phases before the step and the scaled modulation
   logic [63:0]           mod_wide;
   logic [PHASE_BITS-1:0] mod_ff;
   logic [PHASE_BITS-1:0] left_ff;
   logic [PHASE_BITS-1:0] right_ff;

   assign mod_wide = to_phase({{32{req_tdata[31]}}, req_tdata}, PHASE_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mod_ff   <= mod_wide[PHASE_BITS-1:0];
         left_ff  <= left_phase;
         right_ff <= right_phase;
      end
   end

   // waveform generation, one unit per channel
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;

   sdo_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave_left (
      .waveform  (waveform_ff),
      .phase     (left_ff),
      .phase_mod (mod_ff),
      .sample    (left_sample)
   );

   sdo_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave_right (
      .waveform  (waveform_ff),
      .phase     (right_ff),
      .phase_mod (mod_ff),
      .sample    (right_sample)
   );

   // result register
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   assign rsp_data_in = RSP_W'({right_sample, left_sample});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv & s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
